// ===== design/multi_thread_input_macro_sequencer_unit_assert.svh =====
// Assertion macros for the macro sequencer.
`ifndef MULTI_THREAD_INPUT_MACRO_SEQUENCER_UNIT_ASSERT_SVH
`define MULTI_THREAD_INPUT_MACRO_SEQUENCER_UNIT_ASSERT_SVH

// Implication checked at every rising edge, off during reset.
`define MSEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define MSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mseq_pkg.sv =====
`default_nettype none
package mseq_pkg;
    localparam int KIND_W    = 4;
    localparam int OPND_W    = 32;
    localparam int TGT_W     = 8;
    localparam int EVKIND_W  = 3;
    localparam int KEY_W     = 16;
    localparam int THREAD_W  = 3;
    localparam int SLOT_W    = 5;

    localparam logic [KIND_W-1:0] KIND_KEYUP    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MOUSE_HI = 4'd7;
    localparam logic [KIND_W-1:0] KIND_WAIT     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ACT      = 4'd9;
    localparam logic [KIND_W-1:0] KIND_DEACT    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_LE_ACT   = 4'd11;
    localparam logic [KIND_W-1:0] KIND_LE_DEACT = 4'd12;
    localparam logic [KIND_W-1:0] KIND_GE_ACT   = 4'd13;
    localparam logic [KIND_W-1:0] KIND_GE_DEACT = 4'd14;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    localparam logic REG_START = 1'b0;
    localparam logic REG_LOOP  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [OPND_W-1:0] operand;
        logic signed [TGT_W-1:0]  target;
    } entry_t;
endpackage
`default_nettype wire

// ===== design/mseq_if.sv =====
`default_nettype none
interface mseq_in_if;
    import mseq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [31:0]              now_ms;
    logic                     enable;
    logic                     injection_allowed;
    logic signed [31:0]       monitored_level;
    logic [THREAD_W-1:0]      thread_sel;
    logic [SLOT_W-1:0]        slot;
    logic [KIND_W-1:0]        entry_kind;
    logic signed [OPND_W-1:0] entry_operand;
    logic signed [TGT_W-1:0]  entry_target;
    logic                     ends_program;
    modport source (output valid, action, now_ms, enable, injection_allowed,
        monitored_level, thread_sel, slot, entry_kind, entry_operand, entry_target,
        ends_program, input ready);
    modport sink (input valid, action, now_ms, enable, injection_allowed,
        monitored_level, thread_sel, slot, entry_kind, entry_operand, entry_target,
        ends_program, output ready);
endinterface

interface mseq_out_if;
    import mseq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [EVKIND_W-1:0]   event_kind;
    logic [KEY_W-1:0]      key_code;
    logic [THREAD_W-1:0]   source_thread;
    logic                  last;
    modport source (output valid, event_kind, key_code, source_thread, last,
        input ready);
    modport sink (input valid, event_kind, key_code, source_thread, last,
        output ready);
endinterface
`default_nettype wire

// ===== design/multi_thread_input_macro_sequencer_unit.sv =====
`default_nettype none
// A load is written to program memory from ST_IDLE. A tick visits each thread slot in
// turn (memory read, then execute), then goes through ST_EMIT, plus output stalls.
// The input is ready only in ST_IDLE, so a new tick is taken only after the last is done.
// The walk is set by the single read port of the program memory and the thread order.
// Reset: all control state, lengths, counters and masks clear; program memory
// holds no defined contents until written.
module multi_thread_input_macro_sequencer_unit #(
    parameter int NUM_THREADS = 8,
    parameter int MAX_ACTIONS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mseq_in_if.sink          in_ch,
    mseq_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mseq_pkg::*;
    `include "multi_thread_input_macro_sequencer_unit_assert.svh"

    localparam int TI_W  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int AI_W  = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int PC_W  = 6;
    localparam int DEPTH = NUM_THREADS * MAX_ACTIONS;
    localparam int ADR_W = TI_W + AI_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // program memory, one read and one write port
    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [ADR_W-1:0]   rd_addr;
    logic               mem_we;
    logic [ADR_W-1:0]   wr_addr;

    logic [7:0]         start_mask_reg, loop_mask_reg;
    logic [PC_W-1:0]    len_reg [NUM_THREADS];
    logic [PC_W-1:0]    pc_reg  [NUM_THREADS];
    logic [NUM_THREADS-1:0] run_reg, wait_reg;
    logic [31:0]        wstart_reg [NUM_THREADS];
    logic               macro_reg;

    logic [1:0]         state_reg;
    logic [TI_W-1:0]    thr_reg;
    logic               go_reg;   // current thread executes this slot
    logic [31:0]        now_reg;
    logic               inj_reg;
    logic signed [31:0] lvl_reg;
    logic               emitted_reg;
    // output register plus one pending event held back so last can be set
    logic               pend_reg;
    logic [EVKIND_W-1:0] pk_reg;
    logic [KEY_W-1:0]   pc16_reg;
    logic [THREAD_W-1:0] pt_reg;
    logic               ov_reg, ol_reg;
    logic [EVKIND_W-1:0] ok_reg;
    logic [KEY_W-1:0]   okc_reg;
    logic [THREAD_W-1:0] ot_reg;

    logic in_fire, out_fire, cfg_wr, last_thr;
    logic load_ok;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_LOOP) ? {24'd0, loop_mask_reg}
                                             : {24'd0, start_mask_reg};
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = ov_reg && out_ch.ready;
    assign out_ch.valid = ov_reg;
    assign out_ch.event_kind = ok_reg;
    assign out_ch.key_code = okc_reg;
    assign out_ch.source_thread = ot_reg;
    assign out_ch.last = ol_reg;
    assign last_thr = (32'(thr_reg) == NUM_THREADS - 1);
    assign load_ok = (32'(in_ch.thread_sel) < NUM_THREADS)
                  && (32'(in_ch.slot) < MAX_ACTIONS);
    assign mem_we  = in_fire && in_ch.action == ACTION_LOAD && load_ok;
    assign wr_addr = ADR_W'(32'(in_ch.thread_sel) * MAX_ACTIONS + 32'(in_ch.slot));

    // current thread's counter after program-end handling
    logic [PC_W-1:0] pc_eff;
    logic            at_end;
    assign at_end = pc_reg[thr_reg] >= len_reg[thr_reg];
    assign pc_eff = at_end ? '0 : pc_reg[thr_reg];
    assign rd_addr = ADR_W'(32'(thr_reg) * MAX_ACTIONS + 32'(pc_eff[AI_W-1:0]));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= '{in_ch.entry_kind, in_ch.entry_operand, in_ch.entry_target};
        rd_data_reg <= mem[rd_addr];
    end

    // execute decode
    logic [31:0] elapsed, wst;
    logic        wdone, cond, is_tgt, tgt_ok, tgt_run, is_ev;
    logic [TI_W-1:0] tgt_idx;
    always_comb
    begin
        wst     = wait_reg[thr_reg] ? wstart_reg[thr_reg] : now_reg;
        elapsed = now_reg - wst;
        wdone   = (rd_data_reg.operand <= 0) || (elapsed >= 32'(rd_data_reg.operand));
        cond    = 1'b0;
        tgt_run = 1'b0;
        is_tgt  = 1'b0;
        case (rd_data_reg.kind)
            KIND_ACT:      begin is_tgt = 1'b1; cond = 1'b1; tgt_run = 1'b1; end
            KIND_DEACT:    begin is_tgt = 1'b1; cond = 1'b1; end
            KIND_LE_ACT:   begin is_tgt = 1'b1; cond = lvl_reg <= rd_data_reg.operand;
                                 tgt_run = 1'b1; end
            KIND_LE_DEACT: begin is_tgt = 1'b1; cond = lvl_reg <= rd_data_reg.operand; end
            KIND_GE_ACT:   begin is_tgt = 1'b1; cond = lvl_reg >= rd_data_reg.operand;
                                 tgt_run = 1'b1; end
            KIND_GE_DEACT: begin is_tgt = 1'b1; cond = lvl_reg >= rd_data_reg.operand; end
            default:       ;
        endcase
        tgt_ok  = (rd_data_reg.target >= 0) && (32'(rd_data_reg.target) < NUM_THREADS);
        tgt_idx = TI_W'(rd_data_reg.target[TGT_W-2:0]);
        is_ev   = (rd_data_reg.kind <= KIND_MOUSE_HI) && inj_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_mask_reg <= '0;
            loop_mask_reg <= '0;
            run_reg <= '0;
            wait_reg <= '0;
            macro_reg <= 1'b0;
            thr_reg <= '0;
            go_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            emitted_reg <= 1'b0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                len_reg[i] <= '0;
                pc_reg[i] <= '0;
                wstart_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == REG_LOOP)
                    loop_mask_reg <= pwdata[7:0];
                else
                    start_mask_reg <= pwdata[7:0];
            end
            if (out_fire)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_ch.action == ACTION_LOAD)
                        begin
                            if (load_ok && in_ch.ends_program)
                                len_reg[in_ch.thread_sel[TI_W-1:0]] <= PC_W'(in_ch.slot) + 1'b1;
                        end
                        else if (!in_ch.enable)
                        begin
                            macro_reg <= 1'b0;
                            run_reg <= '0;
                        end
                        else
                        begin
                            if (!macro_reg)
                            begin
                                macro_reg <= 1'b1;
                                wait_reg <= '0;
                                for (int i = 0; i < NUM_THREADS; i++)
                                begin
                                    pc_reg[i] <= '0;
                                    run_reg[i] <= start_mask_reg[i];
                                end
                            end
                            now_reg <= in_ch.now_ms;
                            inj_reg <= in_ch.injection_allowed;
                            lvl_reg <= in_ch.monitored_level;
                            thr_reg <= '0;
                            emitted_reg <= 1'b0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    go_reg <= 1'b0;
                    state_reg <= ST_EXEC;
                    if (run_reg[thr_reg] && len_reg[thr_reg] != '0)
                    begin
                        if (at_end && !loop_mask_reg[thr_reg])
                        begin
                            run_reg[thr_reg] <= 1'b0;
                            pc_reg[thr_reg] <= '0;
                            wait_reg[thr_reg] <= 1'b0;
                        end
                        else
                        begin
                            pc_reg[thr_reg] <= pc_eff;
                            go_reg <= 1'b1;
                        end
                    end
                end
                ST_EXEC:
                begin
                    if (!go_reg)
                    begin
                        state_reg <= last_thr ? ST_EMIT : ST_READ;
                        thr_reg <= last_thr ? thr_reg : thr_reg + 1'b1;
                    end
                    else if (pend_reg && ov_reg && !out_fire && is_ev)
                        state_reg <= ST_EXEC;   // output busy, hold
                    else
                    begin
                        state_reg <= last_thr ? ST_EMIT : ST_READ;
                        thr_reg <= last_thr ? thr_reg : thr_reg + 1'b1;
                        if (rd_data_reg.kind == KIND_WAIT)
                        begin
                            wstart_reg[thr_reg] <= wst;
                            wait_reg[thr_reg] <= !wdone;
                            if (wdone)
                                pc_reg[thr_reg] <= pc_reg[thr_reg] + 1'b1;
                        end
                        else
                        begin
                            // self activation restarts at 0, then still steps past it
                            if (is_tgt && cond && tgt_ok && tgt_run && tgt_idx == thr_reg)
                                pc_reg[thr_reg] <= PC_W'(1);
                            else
                                pc_reg[thr_reg] <= pc_reg[thr_reg] + 1'b1;
                            if (is_tgt && cond && tgt_ok)
                            begin
                                run_reg[tgt_idx] <= tgt_run;
                                if (tgt_run && tgt_idx != thr_reg)
                                    pc_reg[tgt_idx] <= '0;
                            end
                            if (is_ev)
                            begin
                                if (pend_reg)
                                begin
                                    ov_reg <= 1'b1;
                                    ok_reg <= pk_reg;
                                    okc_reg <= pc16_reg;
                                    ot_reg <= pt_reg;
                                    ol_reg <= 1'b0;
                                end
                                pend_reg <= 1'b1;
                                emitted_reg <= 1'b1;
                                pk_reg <= EVKIND_W'(rd_data_reg.kind);
                                pc16_reg <= (rd_data_reg.kind <= KIND_KEYUP)
                                          ? rd_data_reg.operand[KEY_W-1:0] : '0;
                                pt_reg <= THREAD_W'(thr_reg);
                            end
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!pend_reg)
                        state_reg <= ST_IDLE;
                    else if (!ov_reg || out_fire)
                    begin
                        ov_reg <= 1'b1;
                        ok_reg <= pk_reg;
                        okc_reg <= pc16_reg;
                        ot_reg <= pt_reg;
                        ol_reg <= 1'b1;
                        pend_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `MSEQ_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == ST_IDLE)
    `MSEQ_ASSERT_IMP(a_pend_only_busy, clk, rst_n, state_reg == ST_IDLE, !pend_reg)
    `MSEQ_ASSERT_NEXT(a_emit_flag, clk, rst_n,
        state_reg == ST_EMIT && pend_reg && (!ov_reg || out_fire), ov_reg && ol_reg)
    `MSEQ_ASSERT_IMP(a_pend_emitted, clk, rst_n, pend_reg, emitted_reg)
endmodule
`default_nettype wire
